// File: rtl/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request line parser package
// Shared codes, character constants, the result type and small helper
// functions for the request line parser.
// ----------------------------------------------------------------------------
package hrlp_pkg;

  // Parser phase within one request line.
  typedef enum logic [1:0] {
    PH_METHOD  = 2'd0,
    PH_URI     = 2'd1,
    PH_VERSION = 2'd2
  } phase_t;

  // Result status codes.
  localparam logic [1:0] ST_BUSY   = 2'd0;
  localparam logic [1:0] ST_ACCEPT = 2'd1;
  localparam logic [1:0] ST_ERROR  = 2'd2;

  // Method codes.
  localparam logic [1:0] M_NONE = 2'd0;
  localparam logic [1:0] M_GET  = 2'd1;
  localparam logic [1:0] M_POST = 2'd2;

  // Store field codes.
  localparam logic [1:0] SF_NONE    = 2'd0;
  localparam logic [1:0] SF_URI     = 2'd1;
  localparam logic [1:0] SF_VERSION = 2'd2;

  // Character constants.
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_O     = 8'h4f;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_UNDER = 8'd95;
  localparam logic [7:0] CH_NUL   = 8'd0;

  // Exclusive bounds of the allowed character ranges.
  localparam logic [7:0] LOWER_LO = 8'd96;
  localparam logic [7:0] LOWER_HI = 8'd123;
  localparam logic [7:0] DIGIT_LO = 8'd45;
  localparam logic [7:0] DIGIT_HI = 8'd58;
  localparam logic [7:0] UPPER_LO = 8'd64;
  localparam logic [7:0] UPPER_HI = 8'd91;

  // One result item.
  typedef struct packed {
    logic [1:0] status;
    logic [1:0] method;
    logic [1:0] store_field;
    logic [7:0] store_pos;
    logic [7:0] store_byte;
  } res_t;

  // Letters, digits, '.', '/' and '_'.
  function automatic logic allowed_char(logic [7:0] c);
    return ((c > LOWER_LO) && (c < LOWER_HI)) ||
           ((c > DIGIT_LO) && (c < DIGIT_HI)) ||
           ((c > UPPER_LO) && (c < UPPER_HI)) ||
           (c == CH_UNDER);
  endfunction

  // Length of the method text including its trailing space.
  function automatic logic [2:0] method_len(logic [1:0] m);
    return (m == M_GET) ? 3'd4 : 3'd5;
  endfunction

  // Expected method character at a given match position.
  function automatic logic [7:0] method_char(logic [1:0] m, logic [2:0] pos);
    logic [7:0] c;
    if (m == M_GET) begin
      unique case (pos[1:0])
        2'd0:    c = CH_G;
        2'd1:    c = CH_E;
        2'd2:    c = CH_T;
        default: c = CH_SPACE;
      endcase
    end else begin
      unique case (pos)
        3'd0:    c = CH_P;
        3'd1:    c = CH_O;
        3'd2:    c = CH_S;
        3'd3:    c = CH_T;
        default: c = CH_SPACE;
      endcase
    end
    return c;
  endfunction

endpackage

// File: rtl/http_request_line_parser_top.sv
// ----------------------------------------------------------------------------
// HTTP request line parser
// Parses a request line one byte per transfer and reports every URI and
// version character with its position.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one byte of the request
//   line per transfer, with last_byte set on the final byte. The output
//   channel (out_valid/out_ready) carries exactly one result per input
//   byte, in order: status, method and an optional stored character.
//   A byte is taken into an input register; the parser state update and the
//   result are computed from it and written to the output register once
//   that register is free. While the receiver does not stall, one byte per
//   cycle is sustained; the state update is the only loop in the design.
//   When the receiver stalls, the finished result stays in the output
//   register and the input register still takes one more byte; in_ready then
//   drops until the output register is freed. in_ready depends
//   combinationally on out_ready.
//   Reset clears both pipeline registers and returns the parser to the start
//   of a line with no accepted line on record. After one line is accepted,
//   every later byte is reported as rejected until the next reset.
// ----------------------------------------------------------------------------
module http_request_line_parser_top #(
  parameter int URI_CAP     = 256,
  parameter int VERSION_CAP = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_in,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [1:0] method,
  output logic [1:0] store_field,
  output logic [7:0] store_pos,
  output logic [7:0] store_byte
);
  import hrlp_pkg::*;

  // The field length counter only needs to reach the larger capacity minus one.
  localparam int MAX_CAP = (URI_CAP > VERSION_CAP) ? URI_CAP : VERSION_CAP;
  localparam int LEN_W   = $clog2(MAX_CAP);

  // Input register: one byte waiting for the parser.
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_last;

  // The output register is free when empty or when its result transfers now.
  logic out_free;
  logic advance;
  res_t res;

  assign out_free = !out_valid || out_ready;
  assign advance  = hold_valid && out_free;
  assign in_ready = !hold_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_byte <= byte_in;
      hold_last <= last_byte;
    end
  end

  hrlp_core #(
    .URI_CAP     (URI_CAP),
    .VERSION_CAP (VERSION_CAP),
    .LEN_W       (LEN_W)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .byte_in   (hold_byte),
    .last_byte (hold_last),
    .res       (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status      <= res.status;
      method      <= res.method;
      store_field <= res.store_field;
      store_pos   <= res.store_pos;
      store_byte  <= res.store_byte;
    end
  end

endmodule

// File: rtl/hrlp_core.sv
// ----------------------------------------------------------------------------
// HTTP request line parser core
// Holds the per-line parser state and computes the result of one byte.
// State advances only when the caller signals that the byte is consumed.
// ----------------------------------------------------------------------------
module hrlp_core #(
  parameter int URI_CAP     = 256,
  parameter int VERSION_CAP = 16,
  parameter int LEN_W       = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic [7:0]    byte_in,
  input  logic          last_byte,
  output hrlp_pkg::res_t res
);
  import hrlp_pkg::*;

  localparam logic [LEN_W-1:0] URI_LAST = LEN_W'(URI_CAP - 1);
  localparam logic [LEN_W-1:0] VER_LAST = LEN_W'(VERSION_CAP - 1);

  phase_t           phase, phase_next;
  logic [2:0]       match_pos, match_pos_next;
  logic [1:0]       method_seen, method_seen_next;
  logic [LEN_W-1:0] field_len, field_len_next;
  logic             line_done, line_done_next;
  logic             error_seen, error_seen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_METHOD;
      match_pos   <= '0;
      method_seen <= M_NONE;
      field_len   <= '0;
      line_done   <= 1'b0;
      error_seen  <= 1'b0;
    end else if (advance) begin
      phase       <= phase_next;
      match_pos   <= match_pos_next;
      method_seen <= method_seen_next;
      field_len   <= field_len_next;
      line_done   <= line_done_next;
      error_seen  <= error_seen_next;
    end
  end

  always_comb begin
    logic err;
    logic ok_char;
    err              = 1'b0;
    ok_char          = allowed_char(byte_in);
    phase_next       = phase;
    match_pos_next   = match_pos;
    method_seen_next = method_seen;
    field_len_next   = field_len;
    line_done_next   = line_done;
    error_seen_next  = error_seen;
    res              = '0;

    if (line_done) begin
      res.status = ST_ERROR;
    end else if (error_seen) begin
      res.status = ST_ERROR;
      if (last_byte) begin
        phase_next       = PH_METHOD;
        match_pos_next   = '0;
        method_seen_next = M_NONE;
        field_len_next   = '0;
        error_seen_next  = 1'b0;
      end
    end else begin
      unique case (phase)
        PH_METHOD: begin
          if (match_pos == 3'd0) begin
            if (byte_in == CH_G) begin
              method_seen_next = M_GET;
              match_pos_next   = 3'd1;
            end else if (byte_in == CH_P) begin
              method_seen_next = M_POST;
              match_pos_next   = 3'd1;
            end else begin
              err = 1'b1;
            end
          end else if ((match_pos >= method_len(method_seen)) ||
                       (byte_in != method_char(method_seen, match_pos))) begin
            err = 1'b1;
          end else begin
            match_pos_next = match_pos + 3'd1;
            if (match_pos_next == method_len(method_seen)) begin
              phase_next     = PH_URI;
              field_len_next = '0;
              res.method     = method_seen;
            end
          end
          if (last_byte) begin
            err = 1'b1;
          end
        end
        PH_URI: begin
          res.method = method_seen;
          if (last_byte) begin
            err = 1'b1;
          end else if (ok_char && (field_len != URI_LAST)) begin
            res.store_field = SF_URI;
            res.store_pos   = 8'(field_len);
            res.store_byte  = byte_in;
            field_len_next  = field_len + 1'b1;
          end else if ((byte_in == CH_SPACE) && (field_len != '0)) begin
            // URI terminator is reported as a zero byte.
            res.store_field = SF_URI;
            res.store_pos   = 8'(field_len);
            res.store_byte  = CH_NUL;
            field_len_next  = '0;
            phase_next      = PH_VERSION;
          end else begin
            err = 1'b1;
          end
        end
        PH_VERSION: begin
          res.method = method_seen;
          if (ok_char && (field_len != VER_LAST)) begin
            res.store_field = SF_VERSION;
            res.store_pos   = 8'(field_len);
            res.store_byte  = byte_in;
            field_len_next  = field_len + 1'b1;
            if (last_byte) begin
              res.status     = ST_ACCEPT;
              line_done_next = 1'b1;
              phase_next     = PH_METHOD;
              match_pos_next = '0;
              field_len_next = '0;
            end
          end else begin
            err = 1'b1;
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase

      if (err) begin
        res              = '0;
        res.status       = ST_ERROR;
        phase_next       = PH_METHOD;
        match_pos_next   = '0;
        method_seen_next = M_NONE;
        field_len_next   = '0;
        error_seen_next  = !last_byte;
      end
    end
  end

endmodule

// File: rtl/hrlp_checker.sv
// ----------------------------------------------------------------------------
// HTTP request line parser port checker
// Watches the top level ports and flags results that break the output rules.
// ----------------------------------------------------------------------------
module hrlp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [1:0] method,
  input logic [1:0] store_field,
  input logic [7:0] store_pos,
  input logic [7:0] store_byte
);
  import hrlp_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(method) &&
      $stable(store_field) && $stable(store_pos) && $stable(store_byte))
    else $error("stalled result changed");

  // An error result carries nothing else.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_ERROR) |->
      (method == M_NONE) && (store_field == SF_NONE) &&
      (store_pos == 8'd0) && (store_byte == 8'd0))
    else $error("error result with nonzero fields");

  // Without a store, position and byte are zero.
  a_no_store: assert property (@(posedge clk) disable iff (rst)
    out_valid && (store_field == SF_NONE) |->
      (store_pos == 8'd0) && (store_byte == 8'd0))
    else $error("store data without a store");

  // An accepted line always ends on a version character with a known method.
  a_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_ACCEPT) |->
      (store_field == SF_VERSION) && ((method == M_GET) || (method == M_POST)))
    else $error("accepted line without version character");

  // No result is offered right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind http_request_line_parser_top hrlp_checker u_hrlp_checker (.*);
